// File: src/qvr_pkg.sv
// qvr_pkg: widths, item types and pipeline control type for the quaternion rotator
// no dependencies
`timescale 1ns / 1ps

package qvr_pkg;

    localparam int QW   = 16;              // quaternion part width
    localparam int VW   = 16;              // vector component width
    localparam int SQW  = 2 * QW;          // square of a quaternion part
    localparam int PVW  = QW + VW;         // quaternion part times vector component
    localparam int DENW = 2 * QW + 1;      // |q|^2, unsigned
    localparam int SW   = 2 * QW + 2;      // w^2 - |u|^2, signed
    localparam int DOTW = QW + VW + 2;     // u.v, signed
    localparam int CRW  = QW + VW + 1;     // u x v component, signed
    localparam int NW   = 2 * QW + VW + 2; // rotation numerator, signed
    localparam int DW   = 2 * QW + VW + 2; // rounded dividend, unsigned
    localparam int DVW  = DENW + 1;        // divisor 2|q|^2
    localparam int QB   = VW + 1;          // quotient bits

    typedef struct packed {
        logic signed [QW-1:0] quat_w;
        logic signed [QW-1:0] quat_x;
        logic signed [QW-1:0] quat_y;
        logic signed [QW-1:0] quat_z;
        logic signed [VW-1:0] vec_x;
        logic signed [VW-1:0] vec_y;
        logic signed [VW-1:0] vec_z;
    } t_in_item;

    typedef struct packed {
        logic signed [VW-1:0] rot_x;
        logic signed [VW-1:0] rot_y;
        logic signed [VW-1:0] rot_z;
        logic                 clipped;
        logic                 zero_quat;
    } t_out_item;

    typedef struct packed {
        logic valid;
        logic zero;
    } t_ctl;

endpackage

// File: src/qvr_prod.sv
// qvr_prod: first two pipeline stages, partial products then norm, s, dot and cross sums
// depends on qvr_pkg
`timescale 1ns / 1ps

module qvr_prod import qvr_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  t_in_item               i_item,
    output t_ctl                   o_ctl,
    output t_in_item               o_item,
    output logic [DENW-1:0]        o_den,
    output logic signed [SW-1:0]   o_s,
    output logic signed [DOTW-1:0] o_dot,
    output logic signed [CRW-1:0]  o_cx,
    output logic signed [CRW-1:0]  o_cy,
    output logic signed [CRW-1:0]  o_cz
);

    // stage a: products
    logic                  r_a_valid;
    t_in_item              r_a_item;
    logic [SQW-1:0]        r_ww, r_xx, r_yy, r_zz;
    logic signed [PVW-1:0] r_xvx, r_yvy, r_zvz;
    logic signed [PVW-1:0] r_yvz, r_zvy, r_zvx, r_xvz, r_xvy, r_yvx;

    // stage b: sums
    logic                   r_b_valid;
    logic                   r_b_zero;
    t_in_item               r_b_item;
    logic [DENW-1:0]        r_den;
    logic signed [SW-1:0]   r_s;
    logic signed [DOTW-1:0] r_dot;
    logic signed [CRW-1:0]  r_cx, r_cy, r_cz;

    logic [DENW-1:0]        n_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_item <= i_item;
            r_ww     <= i_item.quat_w * i_item.quat_w;
            r_xx     <= i_item.quat_x * i_item.quat_x;
            r_yy     <= i_item.quat_y * i_item.quat_y;
            r_zz     <= i_item.quat_z * i_item.quat_z;
            r_xvx    <= i_item.quat_x * i_item.vec_x;
            r_yvy    <= i_item.quat_y * i_item.vec_y;
            r_zvz    <= i_item.quat_z * i_item.vec_z;
            r_yvz    <= i_item.quat_y * i_item.vec_z;
            r_zvy    <= i_item.quat_z * i_item.vec_y;
            r_zvx    <= i_item.quat_z * i_item.vec_x;
            r_xvz    <= i_item.quat_x * i_item.vec_z;
            r_xvy    <= i_item.quat_x * i_item.vec_y;
            r_yvx    <= i_item.quat_y * i_item.vec_x;

            r_b_item <= r_a_item;
            r_den    <= n_den;
            r_b_zero <= (n_den == '0);
            r_s      <= SW'(r_ww) - SW'(r_xx) - SW'(r_yy) - SW'(r_zz);
            r_dot    <= DOTW'(r_xvx) + DOTW'(r_yvy) + DOTW'(r_zvz);
            r_cx     <= CRW'(r_yvz) - CRW'(r_zvy);
            r_cy     <= CRW'(r_zvx) - CRW'(r_xvz);
            r_cz     <= CRW'(r_xvy) - CRW'(r_yvx);
        end
    end

    assign n_den = DENW'(r_ww) + DENW'(r_xx) + DENW'(r_yy) + DENW'(r_zz);

    assign o_ctl.valid = r_b_valid;
    assign o_ctl.zero  = r_b_zero;
    assign o_item      = r_b_item;
    assign o_den       = r_den;
    assign o_s         = r_s;
    assign o_dot       = r_dot;
    assign o_cx        = r_cx;
    assign o_cy        = r_cy;
    assign o_cz        = r_cz;

endmodule

// File: src/qvr_num.sv
// qvr_num: second product stage, numerator sum, then sign split into rounded dividend
// depends on qvr_pkg
`timescale 1ns / 1ps

module qvr_num import qvr_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  t_ctl                   i_ctl,
    input  t_in_item               i_item,
    input  logic [DENW-1:0]        i_den,
    input  logic signed [SW-1:0]   i_s,
    input  logic signed [DOTW-1:0] i_dot,
    input  logic signed [CRW-1:0]  i_cx,
    input  logic signed [CRW-1:0]  i_cy,
    input  logic signed [CRW-1:0]  i_cz,
    output t_ctl                   o_ctl,
    output logic [2:0][DW-1:0]     o_num,
    output logic [2:0]             o_neg,
    output logic [DVW-1:0]         o_dvs
);

    // stage c: products
    t_ctl                 r_c_ctl;
    logic [DENW-1:0]      r_c_den;
    logic signed [NW-1:0] r_sv [3];
    logic signed [NW-1:0] r_du [3];
    logic signed [NW-1:0] r_wc [3];

    // stage d: numerator
    t_ctl                 r_d_ctl;
    logic [DENW-1:0]      r_d_den;
    logic signed [NW-1:0] r_n [3];

    // stage e: magnitude and rounding offset
    t_ctl                 r_e_ctl;
    logic [DENW-1:0]      r_e_den;
    logic [DW-1:0]        r_num [3];
    logic [2:0]           r_neg;

    logic signed [VW-1:0] w_v [3];
    logic signed [QW-1:0] w_u [3];
    logic signed [CRW-1:0] w_c [3];

    assign w_v[0] = i_item.vec_x;
    assign w_v[1] = i_item.vec_y;
    assign w_v[2] = i_item.vec_z;
    assign w_u[0] = i_item.quat_x;
    assign w_u[1] = i_item.quat_y;
    assign w_u[2] = i_item.quat_z;
    assign w_c[0] = i_cx;
    assign w_c[1] = i_cy;
    assign w_c[2] = i_cz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_ctl <= '0;
            r_d_ctl <= '0;
            r_e_ctl <= '0;
        end else if (i_en) begin
            r_c_ctl <= i_ctl;
            r_d_ctl <= r_c_ctl;
            r_e_ctl <= r_d_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_den <= i_den;
            r_d_den <= r_c_den;
            r_e_den <= r_d_den;
            for (int k = 0; k < 3; k++) begin
                r_sv[k] <= i_s * w_v[k];
                r_du[k] <= i_dot * w_u[k];
                r_wc[k] <= i_item.quat_w * w_c[k];
                // numerator wraps freely, the true value fits in NW bits
                r_n[k]  <= r_sv[k] + (r_du[k] <<< 1) + (r_wc[k] <<< 1);
                r_neg[k] <= r_n[k][NW-1];
                // 2|n| + den, ready for a divide by 2 den
                r_num[k] <= (DW'(r_n[k][NW-1] ? -r_n[k] : r_n[k]) << 1) + DW'(r_d_den);
            end
        end
    end

    assign o_ctl = r_e_ctl;
    assign o_neg = r_neg;
    assign o_dvs = {r_e_den, 1'b0};
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            o_num[k] = r_num[k];
        end
    end

    // a zero quaternion leaves nothing but zeros to divide
    a_zero_num: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_e_ctl.valid && r_e_ctl.zero) |-> (r_num[0] == '0 && r_num[1] == '0
            && r_num[2] == '0 && r_e_den == '0))
        else $error("zero quaternion with nonzero dividend");

endmodule

// File: src/qvr_div.sv
// qvr_div: restoring divider, one quotient bit per stage, then saturation and output register
// depends on qvr_pkg
`timescale 1ns / 1ps

module qvr_div import qvr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  t_ctl               i_ctl,
    input  logic [2:0][DW-1:0] i_num,
    input  logic [2:0]         i_neg,
    input  logic [DVW-1:0]     i_dvs,
    output logic               o_valid,
    output t_out_item          o_item
);

    logic [DW-1:0]  s_rem [QB+1][3];
    logic [QB-1:0]  s_q   [QB+1][3];
    logic [DVW-1:0] s_dvs [QB+1];
    logic [2:0]     s_neg [QB+1];
    t_ctl           s_ctl [QB+1];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            s_rem[0][k] = i_num[k];
            s_q[0][k]   = '0;
        end
    end
    assign s_dvs[0] = i_dvs;
    assign s_neg[0] = i_neg;
    assign s_ctl[0] = i_ctl;

    for (genvar g = 0; g < QB; g++) begin : g_stage
        localparam int BIT = QB - 1 - g;

        logic [DW-1:0]  r_rem [3];
        logic [QB-1:0]  r_q   [3];
        logic [DVW-1:0] r_dvs;
        logic [2:0]     r_neg;
        t_ctl           r_ctl;
        logic [DW-1:0]  w_sub;

        assign w_sub = DW'(s_dvs[g]) << BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl <= '0;
            end else if (i_en) begin
                r_ctl <= s_ctl[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dvs <= s_dvs[g];
                r_neg <= s_neg[g];
                for (int k = 0; k < 3; k++) begin
                    if (s_rem[g][k] >= w_sub) begin
                        r_rem[k] <= s_rem[g][k] - w_sub;
                        r_q[k]   <= s_q[g][k] | (QB'(1) << BIT);
                    end else begin
                        r_rem[k] <= s_rem[g][k];
                        r_q[k]   <= s_q[g][k];
                    end
                end
            end
        end

        always_comb begin
            for (int k = 0; k < 3; k++) begin
                s_rem[g+1][k] = r_rem[k];
                s_q[g+1][k]   = r_q[k];
            end
        end
        assign s_dvs[g+1] = r_dvs;
        assign s_neg[g+1] = r_neg;
        assign s_ctl[g+1] = r_ctl;
    end

    // saturation against the signed bounds
    localparam logic [QB-1:0] POS_LIM = QB'((1 << (VW - 1)) - 1);
    localparam logic [QB-1:0] NEG_LIM = QB'(1 << (VW - 1));

    logic                 r_out_valid;
    t_out_item            r_out;
    logic [QB-1:0]        w_lim [3];
    logic [QB-1:0]        w_mag [3];
    logic [2:0]           w_clip;
    logic signed [VW-1:0] w_rot [3];
    t_out_item            n_out;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_lim[k]  = s_neg[QB][k] ? NEG_LIM : POS_LIM;
            w_clip[k] = s_q[QB][k] > w_lim[k];
            w_mag[k]  = w_clip[k] ? w_lim[k] : s_q[QB][k];
            w_rot[k]  = s_neg[QB][k] ? VW'(-w_mag[k]) : VW'(w_mag[k]);
        end
        n_out.zero_quat = s_ctl[QB].zero;
        if (s_ctl[QB].zero) begin
            n_out.rot_x   = '0;
            n_out.rot_y   = '0;
            n_out.rot_z   = '0;
            n_out.clipped = 1'b0;
        end else begin
            n_out.rot_x   = w_rot[0];
            n_out.rot_y   = w_rot[1];
            n_out.rot_z   = w_rot[2];
            n_out.clipped = |w_clip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_out_valid <= s_ctl[QB].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.zero_quat) |-> (r_out.rot_x == '0 && r_out.rot_y == '0
            && r_out.rot_z == '0 && !r_out.clipped))
        else $error("zero quaternion item not cleared");

    a_clip_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.clipped) |-> (
            r_out.rot_x == VW'(POS_LIM) || r_out.rot_x == VW'(NEG_LIM)
            || r_out.rot_y == VW'(POS_LIM) || r_out.rot_y == VW'(NEG_LIM)
            || r_out.rot_z == VW'(POS_LIM) || r_out.rot_z == VW'(NEG_LIM)))
        else $error("clipped item has no component at a bound");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> (r_out_valid && $stable(r_out)))
        else $error("output item changed while held");

endmodule

// File: src/quaternion_vector_rotation_top.sv
// quaternion_vector_rotation_top: an accepted item passes through these stages to o_valid
// (2 product/sum stages, 3 numerator stages, 17 divider stages of one quotient bit, 1 output)
// throughput one item per cycle; the single enable holds every stage while a result is stalled
// reset (i_rst_n low, synchronous) clears all stage valid bits; payload registers keep contents
// depends on qvr_pkg, qvr_prod, qvr_num, qvr_div
`timescale 1ns / 1ps

module quaternion_vector_rotation_top import qvr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    logic w_en;

    t_ctl                   w_p_ctl;
    t_in_item               w_p_item;
    logic [DENW-1:0]        w_den;
    logic signed [SW-1:0]   w_s;
    logic signed [DOTW-1:0] w_dot;
    logic signed [CRW-1:0]  w_cx, w_cy, w_cz;

    t_ctl                   w_n_ctl;
    logic [2:0][DW-1:0]     w_num;
    logic [2:0]             w_neg;
    logic [DVW-1:0]         w_dvs;

    // every stage moves unless a finished item is waiting at the output
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    qvr_prod u_prod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_item  (i_item),
        .o_ctl   (w_p_ctl),
        .o_item  (w_p_item),
        .o_den   (w_den),
        .o_s     (w_s),
        .o_dot   (w_dot),
        .o_cx    (w_cx),
        .o_cy    (w_cy),
        .o_cz    (w_cz)
    );

    qvr_num u_num (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_p_ctl),
        .i_item  (w_p_item),
        .i_den   (w_den),
        .i_s     (w_s),
        .i_dot   (w_dot),
        .i_cx    (w_cx),
        .i_cy    (w_cy),
        .i_cz    (w_cz),
        .o_ctl   (w_n_ctl),
        .o_num   (w_num),
        .o_neg   (w_neg),
        .o_dvs   (w_dvs)
    );

    qvr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_n_ctl),
        .i_num   (w_num),
        .i_neg   (w_neg),
        .i_dvs   (w_dvs),
        .o_valid (o_valid),
        .o_item  (o_item)
    );

endmodule

// File: verif/qvr_checker.sv
// qvr_checker: watches both channels of the quaternion rotator, predicts each result and compares
// depends on qvr_pkg
`timescale 1ns / 1ps

module qvr_checker import qvr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  logic      i_stall_in,
    input  t_in_item  i_item,
    input  logic      i_valid_out,
    input  logic      i_stall_out,
    input  t_out_item i_result,
    output int        o_fail_count,
    output int        o_pending,
    output logic      o_activity
);

    t_out_item rotated_q[$];

    // rounded division, ties away from zero, saturated to the vector width
    function automatic logic signed [VW-1:0] div_round_sat(longint num, longint den,
                                                         inout logic clip);
        longint mag;
        longint q;
        longint lim;
        mag = (num < 0) ? -num : num;
        q = (2 * mag + den) / (2 * den);
        lim = (num < 0) ? (longint'(1) <<< (VW - 1)) : ((longint'(1) <<< (VW - 1)) - 1);
        if (q > lim) begin
            q = lim;
            clip = 1'b1;
        end
        if (num < 0)
            q = -q;
        return q[VW-1:0];
    endfunction

    function automatic t_out_item rotate_vector(t_in_item it);
        longint w, x, y, z, vx, vy, vz;
        longint uu, den, s, d2, cx, cy, cz;
        t_out_item r;
        logic clip;
        w = it.quat_w; x = it.quat_x; y = it.quat_y; z = it.quat_z;
        vx = it.vec_x; vy = it.vec_y; vz = it.vec_z;
        uu = x * x + y * y + z * z;
        den = w * w + uu;
        r = '0;
        clip = 1'b0;
        if (den == 0) begin
            r.zero_quat = 1'b1;
            return r;
        end
        s = w * w - uu;
        d2 = 2 * (x * vx + y * vy + z * vz);
        cx = y * vz - z * vy;
        cy = z * vx - x * vz;
        cz = x * vy - y * vx;
        r.rot_x = div_round_sat(s * vx + d2 * x + 2 * w * cx, den, clip);
        r.rot_y = div_round_sat(s * vy + d2 * y + 2 * w * cy, den, clip);
        r.rot_z = div_round_sat(s * vz + d2 * z + 2 * w * cz, den, clip);
        r.clipped = clip;
        return r;
    endfunction

    assign o_activity = (i_valid && !i_stall_in) || (i_valid_out && !i_stall_out);

    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (i_valid && !i_stall_in)
                rotated_q.push_back(rotate_vector(i_item));
            if (i_valid_out && !i_stall_out) begin
                if (rotated_q.size() == 0) begin
                    o_fail_count <= o_fail_count + 1;
                    if (o_fail_count < 10)
                        $display("unexpected result item %p", i_result);
                end else begin
                    exp_r = rotated_q.pop_front();
                    if (exp_r.rot_x !== i_result.rot_x || exp_r.rot_y !== i_result.rot_y
                        || exp_r.rot_z !== i_result.rot_z
                        || exp_r.clipped !== i_result.clipped
                        || exp_r.zero_quat !== i_result.zero_quat) begin
                        o_fail_count <= o_fail_count + 1;
                        if (o_fail_count < 10)
                            $display("mismatch: expected %p, got %p", exp_r, i_result);
                    end
                end
            end
        end
        o_pending <= rotated_q.size();
    end

endmodule

// File: verif/tb_quaternion_vector_rotation_top.sv
// tb_quaternion_vector_rotation_top: stimulus and verdict for the quaternion rotator
// depends on qvr_pkg, quaternion_vector_rotation_top and qvr_checker
`timescale 1ns / 1ps

module tb_quaternion_vector_rotation_top;
    import qvr_pkg::*;

    localparam int N_RANDOM = 700;
    localparam int WATCHDOG_LIMIT = 5000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_item  i_item = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_item o_item;
    int        fail_count;
    int        pending;
    logic      activity;
    logic      no_idle = 1'b0;
    int        quiet_cycles = 0;
    t_in_item  stimulus_q[$];

    always #5 i_clk = ~i_clk;

    quaternion_vector_rotation_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_item(i_item), .o_valid(o_valid), .i_stall(i_stall), .o_item(o_item)
    );

    qvr_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_stall_in(o_stall),
        .i_item(i_item), .i_valid_out(o_valid), .i_stall_out(i_stall), .i_result(o_item),
        .o_fail_count(fail_count), .o_pending(pending), .o_activity(activity)
    );

    always @(posedge i_clk) begin
        i_stall <= !no_idle && ($urandom_range(0, 99) < 23);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || activity)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic signed [15:0] rand_part(int mode);
        case (mode)
            0: return 16'($urandom_range(0, 65535));
            1: return 16'(int'($urandom_range(0, 32768)) - 16384);
            2: return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
            default: return 16'(int'($urandom_range(0, 8)) - 4);
        endcase
    endfunction

    function automatic t_in_item make_random();
        t_in_item it;
        int qm;
        int vm;
        qm = $urandom_range(0, 9);
        vm = $urandom_range(0, 9);
        qm = (qm < 4) ? 0 : (qm < 7) ? 1 : (qm < 8) ? 2 : 3;
        vm = (vm < 6) ? 0 : (vm < 8) ? 2 : 3;
        it.quat_w = rand_part(qm);
        it.quat_x = rand_part(qm);
        it.quat_y = rand_part(qm);
        it.quat_z = rand_part(qm);
        if ($urandom_range(0, 49) == 0)
            it.quat_w = '0;
        if ($urandom_range(0, 49) == 0) begin
            it.quat_x = '0; it.quat_y = '0; it.quat_z = '0;
        end
        it.vec_x = rand_part(vm);
        it.vec_y = rand_part(vm);
        it.vec_z = rand_part(vm);
        return it;
    endfunction

    function automatic t_in_item item_of(int w, int x, int y, int z, int vx, int vy, int vz);
        t_in_item it;
        it.quat_w = 16'(w); it.quat_x = 16'(x); it.quat_y = 16'(y); it.quat_z = 16'(z);
        it.vec_x = 16'(vx); it.vec_y = 16'(vy); it.vec_z = 16'(vz);
        return it;
    endfunction

    initial begin
        int idx;
        // zero quaternion, with and without a vector
        stimulus_q.push_back(item_of(0, 0, 0, 0, 0, 0, 0));
        stimulus_q.push_back(item_of(0, 0, 0, 0, 32767, -32768, 123));
        // identity, at unit and at non-unit scale
        stimulus_q.push_back(item_of(16384, 0, 0, 0, 1000, -2000, 3000));
        stimulus_q.push_back(item_of(3, 0, 0, 0, 32767, -32768, -1));
        // quarter turns about each axis
        stimulus_q.push_back(item_of(11585, 0, 0, 11585, 10000, 0, 0));
        stimulus_q.push_back(item_of(11585, 11585, 0, 0, 0, 10000, -7));
        stimulus_q.push_back(item_of(11585, 0, 11585, 0, 0, 5, 10000));
        // half turn, pure vector quaternion
        stimulus_q.push_back(item_of(0, 16384, 0, 0, 1, 2, 3));
        // extremes of the parts
        stimulus_q.push_back(item_of(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
        stimulus_q.push_back(item_of(32767, 32767, 32767, 32767, 32767, 32767, 32767));
        stimulus_q.push_back(item_of(-32768, 32767, -32768, 32767, 32767, -32768, 32767));
        // corner vector swung out of range, saturates
        stimulus_q.push_back(item_of(16384, 16384, 0, 0, -32768, -32768, -32768));
        stimulus_q.push_back(item_of(16384, 0, 0, 16384, 32767, 32767, 32767));
        stimulus_q.push_back(item_of(1, 1, 0, 0, -32768, -32768, -32768));
        // tiny quaternions where rounding dominates
        stimulus_q.push_back(item_of(1, 1, 1, 0, 3, -5, 7));
        stimulus_q.push_back(item_of(1, 1, 0, 0, 1, 1, -1));
        stimulus_q.push_back(item_of(0, 0, 0, -1, -3, 3, 0));
        for (idx = 0; idx < N_RANDOM; idx++)
            stimulus_q.push_back(make_random());

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        idx = 0;
        while (stimulus_q.size() > 0 || i_valid) begin
            @(posedge i_clk);
            no_idle <= (idx > 250 && idx < 400);
            if (!i_valid || !o_stall) begin
                if (stimulus_q.size() > 0 && (no_idle || $urandom_range(0, 99) >= 23)) begin
                    i_item <= stimulus_q.pop_front();
                    i_valid <= 1'b1;
                    idx++;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end

        while (pending != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
